### src/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

	// Default bitmap depth in bytes.
	localparam int BITMAP_BYTES_DEF = 128;

	// Most bytes that a 10-bit block number can name.
	localparam int ADDR_BYTES_MAX = 128;

	localparam logic [7:0] CFG_RESET  = 8'd128;
	localparam logic [9:0] FAIL_BLOCK = 10'h3FF;
	localparam logic [7:0] BYTE_FULL  = 8'hFF;

	// Command codes.
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_MARK  = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	// Position of the lowest clear bit of a byte. Returns 0 for a full byte;
	// callers check for that case first.
	function automatic logic [2:0] first_clear(input logic [7:0] b);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (!b[i]) begin
				pos = 3'(i);
			end
		end
		return pos;
	endfunction

endpackage

### src/bba_map_ram.sv
`timescale 1ns / 1ps

// Simple dual-port bitmap memory, one write and one registered read per cycle.
module bba_map_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### src/bitmap_block_allocator.sv
`timescale 1ns / 1ps

// First-fit block allocator over a free-block bitmap held in an on-chip memory,
// one bit per block, a set bit meaning the block is in use. Each request carries
// a command (allocate, free, mark used, query) and yields exactly one response.
// Requests are handled one at a time. An allocate reads one bitmap byte per cycle
// from the memory's registered read port, lowest byte first, examining at most
// the bytes in use (at most 128) before the response is loaded. Free and
// mark-used read the byte, modify it and write it back, then load the response;
// a query reads the byte and then loads the response. An allocate with no bytes
// in use and an out-of-range request skip the memory. The next request
// is accepted in the cycle after the response is loaded, even while that
// response is still stalled. After reset the block clears the memory in a pass,
// one byte per cycle, and stalls requests until it ends; configuration writes
// are taken at any time but should be made while idle.
module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] cmd,
	input  logic [9:0] block_index,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [9:0] result_block,
	output logic       ok,
	output logic       block_free,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
	// Largest number of bytes that can ever be in use.
	localparam logic [7:0] EFF_MAX = 8'((BITMAP_BYTES < ADDR_BYTES_MAX) ?
		BITMAP_BYTES : ADDR_BYTES_MAX);
	localparam logic [AW-1:0] CLR_LAST = AW'(BITMAP_BYTES - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_RMW   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    cfg_q;
	logic [6:0]    idx_q;
	logic [1:0]    cmd_q;
	logic [9:0]    blk_q;
	logic [9:0]    res_block_q;
	logic          res_ok_q;
	logic          res_free_q;
	logic          rsp_valid_q;
	logic [9:0]    rsp_block_q;
	logic          rsp_ok_q;
	logic          rsp_free_q;

	logic [7:0]    active;
	logic          req_fire;
	logic          req_in_range;
	logic          scan_hit;
	logic          scan_last;
	logic [2:0]    scan_pos;
	logic [7:0]    blk_mask;
	logic          rsp_load;

	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [7:0]    ram_wr_data;
	logic          ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	logic [7:0]    ram_rd_data;

	// Bytes that allocation searches and that block numbers may name.
	assign active = (cfg_q > EFF_MAX) ? EFF_MAX : cfg_q;

	assign req_stall    = (state_q != ST_IDLE);
	assign req_fire     = req_valid && !req_stall;
	assign req_in_range = ({1'b0, block_index[9:3]} < active);

	// During a scan the read data belongs to byte idx_q.
	assign scan_hit  = (ram_rd_data != BYTE_FULL);
	assign scan_last = (({1'b0, idx_q} + 8'd1) >= active);
	assign scan_pos  = first_clear(ram_rd_data);
	assign blk_mask  = 8'd1 << blk_q[2:0];

	// The response register is free when empty or being taken this cycle.
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
			end
			ST_IDLE: begin
				if (req_fire) begin
					if (cmd == CMD_ALLOC) begin
						ram_rd_en = (active != 8'd0);
					end else begin
						ram_rd_en   = req_in_range;
						ram_rd_addr = AW'(block_index[9:3]);
					end
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					// Take the lowest clear bit and write the byte back.
					ram_wr_en   = 1'b1;
					ram_wr_addr = AW'(idx_q);
					ram_wr_data = ram_rd_data | (8'd1 << scan_pos);
				end else if (!scan_last) begin
					// Byte is full: fetch the next one.
					ram_rd_en   = 1'b1;
					ram_rd_addr = AW'(idx_q + 7'd1);
				end
			end
			ST_RMW: begin
				ram_wr_addr = AW'(blk_q[9:3]);
				if (cmd_q == CMD_FREE) begin
					ram_wr_en   = 1'b1;
					ram_wr_data = ram_rd_data & ~blk_mask;
				end else if (cmd_q == CMD_MARK) begin
					ram_wr_en   = 1'b1;
					ram_wr_data = ram_rd_data | blk_mask;
				end
			end
			default: begin
			end
		endcase
	end

	bba_map_ram #(
		.DEPTH (BITMAP_BYTES),
		.AW    (AW)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cfg_q       <= CFG_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			// A load refills the response register even as the old response leaves.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						if (cmd == CMD_ALLOC) begin
							state_q <= (active == 8'd0) ? ST_DONE : ST_SCAN;
						end else begin
							state_q <= req_in_range ? ST_RMW : ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_hit || scan_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_RMW: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					cmd_q <= cmd;
					blk_q <= block_index;
					idx_q <= '0;
					// Preset the answer for requests that never touch memory.
					res_block_q <= (cmd == CMD_ALLOC) ? FAIL_BLOCK : block_index;
					res_ok_q    <= 1'b0;
					res_free_q  <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					res_block_q <= {idx_q, scan_pos};
					res_ok_q    <= 1'b1;
				end else if (!scan_last) begin
					idx_q <= idx_q + 7'd1;
				end
			end
			ST_RMW: begin
				res_ok_q   <= 1'b1;
				res_free_q <= (cmd_q == CMD_QUERY) && ((ram_rd_data & blk_mask) == 8'd0);
			end
			ST_DONE: begin
				if (rsp_load) begin
					rsp_block_q <= res_block_q;
					rsp_ok_q    <= res_ok_q;
					rsp_free_q  <= res_free_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_block = rsp_block_q;
	assign ok           = rsp_ok_q;
	assign block_free   = rsp_free_q;

	// The clearing pass writes zeros to every byte it visits.
	a_clear_writes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> ram_wr_en && ram_wr_data == 8'd0)
		else $error("clearing pass did not write zero");

	// No bitmap write while a finished result waits to be loaded.
	a_done_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !ram_wr_en)
		else $error("bitmap written while result pending");

	// A scan never looks past the bytes in use.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> ({1'b0, idx_q} < active))
		else $error("scan index beyond bytes in use");

	// A new response only appears out of the result state.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside result state");

	// A scan that finds a clear bit writes the byte back and moves to the result state.
	a_scan_hit_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && scan_hit |=> state_q == ST_DONE)
		else $error("allocation hit did not finish");

endmodule

### tb/bba_alloc_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the allocator, keeps a shadow bitmap and checks every
// response against the one worked out for the oldest outstanding request.
module bba_alloc_checker
	import bba_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  logic [1:0] cmd,
	input  logic [9:0] block_index,
	input  logic       rsp_valid,
	input  logic       rsp_stall,
	input  logic [9:0] result_block,
	input  logic       ok,
	input  logic       block_free,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output int         errors,
	output int         outstanding
);

	typedef struct packed {
		logic [9:0] blk;
		logic       ok;
		logic       free;
	} alloc_rsp_t;

	logic [7:0] shadow_map [BITMAP_BYTES_DEF];
	logic [7:0] bytes_in_use;
	alloc_rsp_t owed_rsp_q[$];
	int         mismatches;

	// Bytes that allocation searches and that a block index may fall in.
	function automatic int active_bytes();
		int n;
		n = bytes_in_use;
		if (n > BITMAP_BYTES_DEF) n = BITMAP_BYTES_DEF;
		if (n > ADDR_BYTES_MAX) n = ADDR_BYTES_MAX;
		return n;
	endfunction

	// Applies one request to the shadow bitmap and returns the response it owes.
	function automatic alloc_rsp_t apply_command(logic [1:0] op, logic [9:0] idx);
		alloc_rsp_t r;
		int         n;
		int         byte_no;
		bit         found;
		n = active_bytes();
		r.blk = idx;
		r.ok = 1'b0;
		r.free = 1'b0;
		if (op == CMD_ALLOC) begin
			r.blk = FAIL_BLOCK;
			found = 1'b0;
			for (int i = 0; i < n && !found; i++) begin
				for (int j = 0; j < 8 && !found; j++) begin
					if (!shadow_map[i][j]) begin
						shadow_map[i][j] = 1'b1;
						r.blk = 10'(i * 8 + j);
						r.ok = 1'b1;
						found = 1'b1;
					end
				end
			end
		end else begin
			byte_no = idx[9:3];
			if (byte_no < n) begin
				r.ok = 1'b1;
				case (op)
					CMD_FREE: shadow_map[byte_no][idx[2:0]] = 1'b0;
					CMD_MARK: shadow_map[byte_no][idx[2:0]] = 1'b1;
					CMD_QUERY: r.free = !shadow_map[byte_no][idx[2:0]];
					default: ;
				endcase
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_rsp_t want;
		if (!arst_n) begin
			foreach (shadow_map[i]) shadow_map[i] = '0;
			bytes_in_use = CFG_RESET;
			owed_rsp_q.delete();
			mismatches = 0;
		end else begin
			if (cfg_wr_en) bytes_in_use = cfg_wr_data;
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp_q.size() == 0) begin
					if (mismatches < 10) begin
						$display("%t: response with no request outstanding: block %0d ok %0b free %0b",
							$time, result_block, ok, block_free);
					end
					mismatches++;
				end else begin
					want = owed_rsp_q.pop_front();
					if (want.blk !== result_block || want.ok !== ok || want.free !== block_free) begin
						if (mismatches < 10) begin
							$display("%t: mismatch: expected block %0d ok %0b free %0b, got block %0d ok %0b free %0b",
								$time, want.blk, want.ok, want.free, result_block, ok, block_free);
						end
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall) owed_rsp_q.push_back(apply_command(cmd, block_index));
		end
		errors <= mismatches;
		outstanding <= owed_rsp_q.size();
	end

endmodule

### tb/tb_bitmap_block_allocator.sv
`timescale 1ns / 1ps

// Top level of the allocator bench. It only makes stimulus and gives the verdict:
// the checker beside the block keeps the shadow bitmap and compares responses.
module tb_bitmap_block_allocator;
	import bba_pkg::*;

	// Cycles with no handshake on either channel before the run is called hung.
	// The slowest legitimate wait is the clearing pass after reset followed by a
	// full-depth allocate, so this leaves a wide margin.
	localparam int STALL_LIMIT = 5000;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       req_valid   = 1'b0;
	logic       req_stall;
	logic [1:0] cmd         = CMD_ALLOC;
	logic [9:0] block_index = '0;
	logic       rsp_valid;
	logic       rsp_stall   = 1'b0;
	logic [9:0] result_block;
	logic       ok;
	logic       block_free;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = '0;

	// While calm is set neither side inserts idle cycles or stalls.
	bit         calm        = 1'b0;
	int         errors;
	int         outstanding;
	int         idle_cycles = 0;

	bitmap_block_allocator #(
		.BITMAP_BYTES(BITMAP_BYTES_DEF)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.block_index(block_index),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_block(result_block),
		.ok(ok),
		.block_free(block_free),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	bba_alloc_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.block_index(block_index),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_block(result_block),
		.ok(ok),
		.block_free(block_free),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The response side stalls at random about 20 percent of the time, except in calm stretches.
	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 20);
	end

	// Hang detection: any accepted request or response restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Presents one request and returns in the time step of the edge that accepts it,
	// or after the idle gap when one is drawn. Valid stays high into the next request
	// unless an idle gap is drawn, so it is never lowered and raised within one step.
	task automatic issue_request(logic [1:0] op, logic [9:0] idx);
		req_valid <= 1'b1;
		cmd <= op;
		block_index <= idx;
		do @(posedge clk); while (req_stall);
		if (!calm && $urandom_range(99) < 20) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Writes the bytes-in-use register once the block has answered every request.
	// Every request gets a response, so an empty checker queue means the block
	// is idle; the extra cycles only add margin.
	task automatic write_bytes_in_use(logic [7:0] setting);
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= setting;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// A run of random requests under one register setting. The percentages give
	// the share of allocate, free and mark-used; the rest are queries. Most
	// indexes fall inside the active blocks so that commands really change the
	// map; some are drawn over the whole 10-bit range to hit the range check.
	task automatic run_mix(logic [7:0] setting, int count, int pa, int pf, int pm);
		int         span;
		int         roll;
		logic [1:0] op;
		logic [9:0] idx;
		write_bytes_in_use(setting);
		span = (setting > ADDR_BYTES_MAX) ? ADDR_BYTES_MAX * 8 : setting * 8;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < pa) op = CMD_ALLOC;
			else if (roll < pa + pf) op = CMD_FREE;
			else if (roll < pa + pf + pm) op = CMD_MARK;
			else op = CMD_QUERY;
			if (span == 0 || $urandom_range(99) < 12) idx = 10'($urandom);
			else idx = 10'($urandom_range(span - 1));
			issue_request(op, idx);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset setting of 128 bytes. The first request
		// also waits out the clearing pass that follows reset.
		issue_request(CMD_QUERY, 10'd0);
		issue_request(CMD_ALLOC, 10'd1023);
		issue_request(CMD_ALLOC, 10'd0);
		issue_request(CMD_QUERY, 10'd0);
		// Highest block: mark, query, then free twice to show a repeat is harmless.
		issue_request(CMD_MARK, 10'd1023);
		issue_request(CMD_QUERY, 10'd1023);
		issue_request(CMD_FREE, 10'd1023);
		issue_request(CMD_FREE, 10'd1023);
		issue_request(CMD_QUERY, 10'd1023);
		// A block marked ahead of the allocation front must be skipped over.
		issue_request(CMD_MARK, 10'd5);
		issue_request(CMD_MARK, 10'd5);
		issue_request(CMD_ALLOC, 10'd0);
		issue_request(CMD_ALLOC, 10'd0);
		issue_request(CMD_ALLOC, 10'd0);
		issue_request(CMD_ALLOC, 10'd0);
		// A freed hole below the front is the next one handed out.
		issue_request(CMD_FREE, 10'd2);
		issue_request(CMD_ALLOC, 10'd0);

		// One byte in use: fill it, then allocation fails, the index just past the
		// active bytes is out of range for query and free, and so is 1023 for mark.
		write_bytes_in_use(8'd1);
		issue_request(CMD_ALLOC, 10'd0);
		issue_request(CMD_ALLOC, 10'd0);
		issue_request(CMD_QUERY, 10'd8);
		issue_request(CMD_FREE, 10'd8);
		issue_request(CMD_MARK, 10'd1023);

		// No bytes in use: everything fails.
		write_bytes_in_use(8'd0);
		issue_request(CMD_ALLOC, 10'd0);
		issue_request(CMD_QUERY, 10'd0);

		// A setting above 128 is clipped to the full map.
		write_bytes_in_use(8'd255);
		issue_request(CMD_QUERY, 10'd1023);

		// Random part. The first run is allocate heavy so that the scan reaches
		// deep into the full map; small settings fill up fast and exercise the
		// failure path; a later run at 128 marks a lot to fill more of the full map.
		run_mix(8'd128, 250, 70, 10, 10);
		run_mix(8'd1, 100, 40, 25, 15);
		run_mix(8'd2, 100, 40, 25, 15);
		run_mix(8'd5, 150, 40, 25, 15);
		calm <= 1'b1;
		run_mix(8'd16, 200, 40, 25, 15);
		calm <= 1'b0;
		run_mix(8'd200, 100, 35, 20, 25);
		run_mix(8'd128, 200, 40, 10, 40);
		run_mix(8'd0, 20, 40, 20, 20);

		// Drain: wait for the last responses and for any strays.
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### bitmap_block_allocator.f
src/bba_pkg.sv
src/bba_map_ram.sv
src/bitmap_block_allocator.sv
tb/bba_alloc_checker.sv
tb/tb_bitmap_block_allocator.sv
